FILE: src/spd_pkg.sv
// ---------------------------------------------------------------------------
// spd_pkg - shared types and codes of the servo packet deframer
// Byte type, input kind, result kind and status codes, and the result
// record that travels through the output stage.
// ---------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [1:0] status_type;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_GAP  = 1'b1;

   localparam logic RESULT_PARAM   = 1'b0;
   localparam logic RESULT_VERDICT = 1'b1;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_BAD_CSUM  = 2'd1;
   localparam status_type STATUS_BAD_LEN   = 2'd2;
   localparam status_type STATUS_ABORTED   = 2'd3;

   localparam byte_type HEADER_BYTE = 8'hFF;
   localparam byte_type MIN_LENGTH  = 8'd2;
   localparam byte_type MAX_LEN_RESET = 8'd255;

   typedef struct packed {
      logic       result_kind;
      byte_type   data_byte;
      byte_type   byte_index;
      byte_type   frame_id;
      byte_type   instruction_code;
      byte_type   param_count;
      status_type status;
   } result_type;

endpackage : spd_pkg

`default_nettype wire

FILE: src/servo_packet_deframer_top.sv
// ---------------------------------------------------------------------------
// servo_packet_deframer_top - receive-side deframer for servo bus packets
// Hunts for a two-byte 0xFF header, reads id, length, instruction, the
// parameter bytes and the checksum, and reports each parameter byte and a
// final verdict per frame.
// ---------------------------------------------------------------------------
// The block takes one item per clock cycle while req_stall is low: a received
// byte or a line-gap event. Each item is handled in the cycle it is accepted,
// and at most one result item comes of it, registered in the output register
// or the skid register before rsp_valid shows it. Every parameter byte
// is passed out as it arrives together with its index, the frame id, the
// instruction and the parameter count. The checksum byte produces a verdict
// item with status ok or bad checksum; a length below 2 or above max_len
// produces a bad-length verdict as soon as the length byte arrives, and a
// line gap inside a frame produces an aborted verdict carrying what has been
// held so far. The result channel has an output register backed by one skid
// register, so input items keep flowing while a result waits to be taken;
// req_stall rises only once both are full. max_len resets to 255; the user
// must write it via the csr port only while idle; the block does not enforce it.
`default_nettype none

module servo_packet_deframer_top (
   input  wire logic              clock,
   input  wire logic              reset,
   // Configuration port
   input  wire logic              csr_wr_en,
   input  wire spd_pkg::byte_type csr_wr_data,
   // Input channel
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire logic              req_kind,
   input  wire spd_pkg::byte_type req_rx_byte,
   // Result channel
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output logic                   rsp_result_kind,
   output spd_pkg::byte_type      rsp_data_byte,
   output spd_pkg::byte_type      rsp_byte_index,
   output spd_pkg::byte_type      rsp_frame_id,
   output spd_pkg::byte_type      rsp_instruction_code,
   output spd_pkg::byte_type      rsp_param_count,
   output spd_pkg::status_type    rsp_status
);

   import spd_pkg::*;

   // Frame phases.
   localparam logic [2:0] PH_HUNT  = 3'd0;
   localparam logic [2:0] PH_ID    = 3'd1;
   localparam logic [2:0] PH_LEN   = 3'd2;
   localparam logic [2:0] PH_INSTR = 3'd3;
   localparam logic [2:0] PH_PARAM = 3'd4;
   localparam logic [2:0] PH_CSUM  = 3'd5;

   // Deframer state.
   byte_type   max_len_ff;
   logic [2:0] phase_ff,         phase_in;
   logic       prev_was_ff_ff,   prev_was_ff_in;
   byte_type   held_id_ff,       held_id_in;
   byte_type   held_length_ff,   held_length_in;
   byte_type   held_instr_ff,    held_instr_in;
   byte_type   param_counter_ff, param_counter_in;
   byte_type   sum_acc_ff,       sum_acc_in;

   // Output stage: the result register and the skid register behind it.
   result_type out_data_ff;
   logic       out_valid_ff;
   result_type skid_data_ff;
   logic       skid_valid_ff;

   logic       req_accept;
   logic       out_take;
   logic       has_result;
   result_type result;
   byte_type   param_total;
   byte_type   counter_next;
   byte_type   sum_with_byte;

   // The input side stalls only while the skid register is occupied, which
   // keeps req_stall a plain register output.
   assign req_stall  = skid_valid_ff;
   assign req_accept = req_valid && !skid_valid_ff;
   assign out_take   = out_valid_ff && !rsp_stall;

   // Number of parameter bytes implied by the held length.
   assign param_total   = (held_length_ff >= MIN_LENGTH) ? held_length_ff - MIN_LENGTH : '0;
   assign counter_next  = param_counter_ff + 8'd1;
   assign sum_with_byte = sum_acc_ff + req_rx_byte;

   // One pass of the deframer for the item on the input ports.
   always_comb begin
      phase_in         = phase_ff;
      prev_was_ff_in   = prev_was_ff_ff;
      held_id_in       = held_id_ff;
      held_length_in   = held_length_ff;
      held_instr_in    = held_instr_ff;
      param_counter_in = param_counter_ff;
      sum_acc_in       = sum_acc_ff;
      has_result       = 1'b0;

      // Verdicts carry the held id and instruction; the other fields are
      // filled in per case.
      result.result_kind      = RESULT_VERDICT;
      result.data_byte        = '0;
      result.byte_index       = '0;
      result.frame_id         = held_id_ff;
      result.instruction_code = held_instr_ff;
      result.param_count      = '0;
      result.status           = STATUS_OK;

      if (req_kind == KIND_GAP) begin
         prev_was_ff_in = 1'b0;
         if (phase_ff != PH_HUNT) begin
            // A gap inside a frame aborts it with what has been held so far.
            has_result         = 1'b1;
            result.param_count = param_total;
            result.status      = STATUS_ABORTED;
            phase_in           = PH_HUNT;
         end
      end else begin
         unique case (phase_ff)
            PH_ID: begin
               held_id_in = req_rx_byte;
               sum_acc_in = req_rx_byte;
               phase_in   = PH_LEN;
            end
            PH_LEN: begin
               if (req_rx_byte < MIN_LENGTH || req_rx_byte > max_len_ff) begin
                  held_length_in = '0;
                  has_result     = 1'b1;
                  result.status  = STATUS_BAD_LEN;
                  phase_in       = PH_HUNT;
                  prev_was_ff_in = 1'b0;
               end else begin
                  held_length_in = req_rx_byte;
                  sum_acc_in     = sum_with_byte;
                  phase_in       = PH_INSTR;
               end
            end
            PH_INSTR: begin
               held_instr_in    = req_rx_byte;
               sum_acc_in       = sum_with_byte;
               param_counter_in = '0;
               // A frame without parameters goes straight to its checksum.
               phase_in         = (held_length_ff == MIN_LENGTH) ? PH_CSUM : PH_PARAM;
            end
            PH_PARAM: begin
               sum_acc_in               = sum_with_byte;
               param_counter_in         = counter_next;
               if (counter_next >= param_total) begin
                  phase_in = PH_CSUM;
               end
               has_result               = 1'b1;
               result.result_kind       = RESULT_PARAM;
               result.data_byte         = req_rx_byte;
               result.byte_index        = param_counter_ff;
               result.param_count       = param_total;
            end
            PH_CSUM: begin
               has_result         = 1'b1;
               result.param_count = param_total;
               result.status      = (req_rx_byte == ~sum_acc_ff) ? STATUS_OK
                                                                 : STATUS_BAD_CSUM;
               phase_in           = PH_HUNT;
               prev_was_ff_in     = 1'b0;
            end
            default: begin
               // Hunting: two header bytes in a row open a frame and clear
               // everything held from the last one.
               if (req_rx_byte == HEADER_BYTE && prev_was_ff_ff) begin
                  phase_in         = PH_ID;
                  prev_was_ff_in   = 1'b0;
                  held_id_in       = '0;
                  held_length_in   = '0;
                  held_instr_in    = '0;
                  param_counter_in = '0;
                  sum_acc_in       = '0;
               end else begin
                  phase_in       = PH_HUNT;
                  prev_was_ff_in = (req_rx_byte == HEADER_BYTE);
               end
            end
         endcase
      end
   end

   // Configuration register.
   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MAX_LEN_RESET;
      end else if (csr_wr_en) begin
         max_len_ff <= csr_wr_data;
      end
   end

   // Deframer state, updated once per accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HUNT;
         prev_was_ff_ff   <= 1'b0;
         held_id_ff       <= '0;
         held_length_ff   <= '0;
         held_instr_ff    <= '0;
         param_counter_ff <= '0;
         sum_acc_ff       <= '0;
      end else if (req_accept) begin
         phase_ff         <= phase_in;
         prev_was_ff_ff   <= prev_was_ff_in;
         held_id_ff       <= held_id_in;
         held_length_ff   <= held_length_in;
         held_instr_ff    <= held_instr_in;
         param_counter_ff <= param_counter_in;
         sum_acc_ff       <= sum_acc_in;
      end
   end

   // Output stage control. A new result goes to the output register when it
   // is free or being emptied this cycle, and otherwise to the skid register.
   // When the skid register is full no item is accepted, so it only drains.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (out_take) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (req_accept && has_result) begin
         if (!out_valid_ff || out_take) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (out_take) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Output stage payload.
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (out_take) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (req_accept && has_result) begin
         if (!out_valid_ff || out_take) begin
            out_data_ff <= result;
         end else begin
            skid_data_ff <= result;
         end
      end
   end

   assign rsp_valid            = out_valid_ff;
   assign rsp_result_kind      = out_data_ff.result_kind;
   assign rsp_data_byte        = out_data_ff.data_byte;
   assign rsp_byte_index       = out_data_ff.byte_index;
   assign rsp_frame_id         = out_data_ff.frame_id;
   assign rsp_instruction_code = out_data_ff.instruction_code;
   assign rsp_param_count      = out_data_ff.param_count;
   assign rsp_status           = out_data_ff.status;

endmodule : servo_packet_deframer_top

`default_nettype wire
